// ===== src/wtos_pkg.sv =====
// ----------------------------------------------------------------------------
// wtos_pkg
// Shared types and constants for the weighted tardiness order search core.
// ----------------------------------------------------------------------------
package wtos_pkg;

  localparam int LEN_W = 16;
  localparam int DL_W  = 20;
  localparam int WT_W  = 16;
  localparam int LIM_W = 31;
  localparam int TIME_W = 21;
  localparam int PEN_W = 42;
  localparam int ID_W  = 5;
  localparam int ST_W  = 2;

  localparam logic [ST_W-1:0] ST_FOUND    = 2'd0;
  localparam logic [ST_W-1:0] ST_NONE     = 2'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic load;      // store the incoming job
    logic clr_load;  // end of run: clear count and overflow
    logic start;     // reset search position
    logic step;      // one search step (place or retreat)
    logic add_pen;   // add the registered lateness penalty of the placed job
    logic out_rst;   // reset output index
    logic out_adv;   // move to next output position
  } wtos_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic overflow;  // set if a job beyond capacity arrived (or arriving now)
    logic found;     // search reached full depth within the penalty limit
    logic failed;    // search retreated from level zero
    logic can_place; // the next step places a job
    logic out_done;  // current output position is the final one
  } wtos_stat_t;

endpackage

// ===== src/wtos_datapath.sv =====
// ----------------------------------------------------------------------------
// wtos_datapath
// Job storage, search stack and the per-step place/retreat arithmetic.
// ----------------------------------------------------------------------------
module wtos_datapath #(
  parameter int MAX_JOBS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [wtos_pkg::LIM_W-1:0]    tax_limit,
  input  logic [wtos_pkg::LEN_W-1:0]    job_length,
  input  logic [wtos_pkg::DL_W-1:0]     job_deadline,
  input  logic [wtos_pkg::WT_W-1:0]     job_weight,
  input  wtos_pkg::wtos_cmd_t           cmd,
  output wtos_pkg::wtos_stat_t          stat,
  output logic [wtos_pkg::ID_W-1:0]     out_id
);
  import wtos_pkg::*;

  localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam int MW = TIME_W + WT_W;

  // job stores
  logic [LEN_W-1:0] length_store   [MAX_JOBS];
  logic [DL_W-1:0]  deadline_store [MAX_JOBS];
  logic [WT_W-1:0]  weight_store   [MAX_JOBS];

  // search stack
  logic [IW-1:0]     chosen_order   [MAX_JOBS];
  logic [TIME_W-1:0] saved_time     [MAX_JOBS];
  logic [PEN_W-1:0]  saved_penalty  [MAX_JOBS];
  logic [CW-1:0]     next_candidate [MAX_JOBS];

  logic [CW-1:0]     job_count;
  logic              overflow_flag;
  logic [MAX_JOBS-1:0] used_mask;
  logic [CW-1:0]     search_level;
  logic [TIME_W-1:0] elapsed_time;
  logic [PEN_W-1:0]  penalty_sum;
  logic [CW-1:0]     out_idx;

  // first free candidate at or above the current level's start point
  logic [CW-1:0] cand_start;
  logic [CW-1:0] cand;
  logic          cand_ok;
  logic [IW-1:0] lvl_i;
  logic [IW-1:0] cand_i;
  logic [IW-1:0] prev_i;

  assign lvl_i  = search_level[IW-1:0];
  assign cand_start = (search_level < job_count) ? next_candidate[lvl_i] : '0;

  always_comb begin
    cand    = job_count;
    cand_ok = 1'b0;
    for (int i = MAX_JOBS - 1; i >= 0; i--) begin
      if (CW'(i) >= cand_start && CW'(i) < job_count && !used_mask[i]) begin
        cand    = CW'(i);
        cand_ok = 1'b1;
      end
    end
  end

  assign cand_i = cand[IW-1:0];
  assign prev_i = IW'(search_level - 1'b1);

  // placing a job: new time and lateness
  logic [TIME_W-1:0] new_time;
  logic [TIME_W-1:0] late;
  assign new_time = elapsed_time + TIME_W'(length_store[cand_i]);
  assign late = (new_time > TIME_W'(deadline_store[cand_i]))
                ? new_time - TIME_W'(deadline_store[cand_i]) : '0;

  // lateness and weight held for the penalty cycle
  logic [TIME_W-1:0] late_q;
  logic [WT_W-1:0]   wt_q;
  logic [MW-1:0]     late_pen;
  assign late_pen = MW'(late_q) * MW'(wt_q);

  logic over_limit;
  logic at_full;
  logic can_place;
  assign over_limit = penalty_sum > PEN_W'(tax_limit);
  assign at_full    = search_level >= job_count;
  assign can_place  = !over_limit && !at_full && cand_ok;

  assign stat.overflow  = overflow_flag || (job_count >= CW'(MAX_JOBS));
  assign stat.found     = !over_limit && at_full;
  assign stat.failed    = (over_limit || (!at_full && !cand_ok)) && search_level == '0;
  assign stat.can_place = can_place;
  assign stat.out_done  = (out_idx + 1'b1) >= job_count;
  assign out_id         = ID_W'(chosen_order[out_idx[IW-1:0]]) + ID_W'(1);

  // load path and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      job_count     <= '0;
      overflow_flag <= 1'b0;
    end else if (cmd.clr_load) begin
      job_count     <= '0;
      overflow_flag <= 1'b0;
    end else if (cmd.load) begin
      if (job_count < CW'(MAX_JOBS)) job_count <= job_count + 1'b1;
      else overflow_flag <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load && job_count < CW'(MAX_JOBS)) begin
      length_store[job_count[IW-1:0]]   <= job_length;
      deadline_store[job_count[IW-1:0]] <= job_deadline;
      weight_store[job_count[IW-1:0]]   <= job_weight;
    end
  end

  // search position
  always_ff @(posedge clk) begin
    if (rst) begin
      search_level <= '0;
      elapsed_time <= '0;
      penalty_sum  <= '0;
      used_mask    <= '0;
    end else if (cmd.start) begin
      search_level <= '0;
      elapsed_time <= '0;
      penalty_sum  <= '0;
      used_mask    <= '0;
    end else if (cmd.step) begin
      if (can_place) begin
        used_mask[cand_i] <= 1'b1;
        elapsed_time      <= new_time;
        search_level      <= search_level + 1'b1;
      end else if (search_level != '0) begin
        search_level              <= search_level - 1'b1;
        used_mask[chosen_order[prev_i]] <= 1'b0;
        elapsed_time              <= saved_time[prev_i];
        penalty_sum               <= saved_penalty[prev_i];
      end
    end else if (cmd.add_pen) begin
      penalty_sum <= penalty_sum + PEN_W'(late_pen);
    end
  end

  // lateness capture on a place step
  always_ff @(posedge clk) begin
    if (cmd.step && can_place) begin
      late_q <= late;
      wt_q   <= weight_store[cand_i];
    end
  end

  // stack writes
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      next_candidate[0] <= '0;
    end else if (cmd.step && can_place) begin
      next_candidate[lvl_i] <= cand + 1'b1;
      saved_time[lvl_i]     <= elapsed_time;
      saved_penalty[lvl_i]  <= penalty_sum;
      chosen_order[lvl_i]   <= cand_i;
      if (search_level + 1'b1 < CW'(MAX_JOBS))
        next_candidate[IW'(search_level + 1'b1)] <= '0;
    end
  end

  // output position
  always_ff @(posedge clk) begin
    if (rst || cmd.out_rst) out_idx <= '0;
    else if (cmd.out_adv)   out_idx <= out_idx + 1'b1;
  end

endmodule

// ===== src/wtos_ctrl.sv =====
// ----------------------------------------------------------------------------
// wtos_ctrl
// Controller: load, search, and result emission sequencing.
// ----------------------------------------------------------------------------
module wtos_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 last_job,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [wtos_pkg::ST_W-1:0] out_status,
  output logic                 out_last,
  output logic                 out_use_id,
  output wtos_pkg::wtos_cmd_t  cmd,
  input  wtos_pkg::wtos_stat_t stat
);
  import wtos_pkg::*;

  localparam logic [2:0] S_LOAD    = 3'd0;
  localparam logic [2:0] S_SEARCH  = 3'd1;
  localparam logic [2:0] S_EMIT    = 3'd2;
  localparam logic [2:0] S_SINGLE  = 3'd3;
  localparam logic [2:0] S_PENALTY = 3'd4;

  logic [2:0] state, state_next;
  logic [ST_W-1:0] code, code_next;
  logic in_acc, out_acc;

  assign in_stall = (state != S_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = (state == S_EMIT) || (state == S_SINGLE);
  assign out_acc  = out_valid && !out_stall;
  assign out_status = (state == S_EMIT) ? ST_FOUND : code;
  assign out_last   = (state == S_SINGLE) || stat.out_done;
  assign out_use_id = (state == S_EMIT);

  // next state and commands
  always_comb begin
    state_next = state;
    code_next  = code;
    cmd        = '0;
    unique case (state)
      S_LOAD: begin
        if (in_acc) begin
          cmd.load = 1'b1;
          if (last_job) begin
            cmd.start = 1'b1;
            if (stat.overflow) begin
              code_next  = ST_OVERFLOW;
              state_next = S_SINGLE;
            end else begin
              state_next = S_SEARCH;
            end
          end
        end
      end
      S_SEARCH: begin
        if (stat.found) begin
          cmd.out_rst = 1'b1;
          state_next  = S_EMIT;
        end else if (stat.failed) begin
          code_next  = ST_NONE;
          state_next = S_SINGLE;
        end else begin
          cmd.step = 1'b1;
          if (stat.can_place) state_next = S_PENALTY;
        end
      end
      S_PENALTY: begin
        cmd.add_pen = 1'b1;
        state_next  = S_SEARCH;
      end
      S_EMIT: begin
        if (out_acc) begin
          cmd.out_adv = 1'b1;
          if (stat.out_done) begin
            cmd.clr_load = 1'b1;
            state_next   = S_LOAD;
          end
        end
      end
      S_SINGLE: begin
        if (out_acc) begin
          cmd.clr_load = 1'b1;
          state_next   = S_LOAD;
        end
      end
      default: state_next = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      code  <= ST_FOUND;
    end else begin
      state <= state_next;
      code  <= code_next;
    end
  end

endmodule

// ===== src/weighted_tardiness_order_search_core.sv =====
// sequencing: jobs load one per cycle while the input is open; after the last
// job the search places a job and adds its penalty, or retreats, until it
// sees the end, then emits the results (one per job, or one status result)
// throughput: one run at a time; input stalls from last job until final result
// reset: synchronous active high, clears counts, search state and sets limit 1
// ----------------------------------------------------------------------------
// weighted_tardiness_order_search_core
// Loads jobs and searches for the first job order within the penalty limit.
// ----------------------------------------------------------------------------
module weighted_tardiness_order_search_core #(
  parameter int MAX_JOBS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [wtos_pkg::LIM_W-1:0]    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wtos_pkg::LEN_W-1:0]    job_length,
  input  logic [wtos_pkg::DL_W-1:0]     job_deadline,
  input  logic [wtos_pkg::WT_W-1:0]     job_weight,
  input  logic                          last_job,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wtos_pkg::ST_W-1:0]     status,
  output logic [wtos_pkg::ID_W-1:0]     job_id,
  output logic                          last
);
  import wtos_pkg::*;

  logic [LIM_W-1:0] tax_limit;
  wtos_cmd_t  cmd;
  wtos_stat_t stat;
  logic [ID_W-1:0] dp_id;
  logic use_id;

  // penalty limit register
  always_ff @(posedge clk) begin
    if (rst) tax_limit <= LIM_W'(1);
    else if (cfg_we) tax_limit <= cfg_wdata;
  end

  wtos_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .last_job, .out_valid, .out_stall,
    .out_status(status), .out_last(last), .out_use_id(use_id), .cmd, .stat
  );

  wtos_datapath #(.MAX_JOBS(MAX_JOBS)) u_dp (
    .clk, .rst, .tax_limit, .job_length, .job_deadline, .job_weight,
    .cmd, .stat, .out_id(dp_id)
  );

  assign job_id = use_id ? dp_id : '0;

endmodule

// ===== src/wtos_checker.sv =====
// ----------------------------------------------------------------------------
// wtos_checker
// Port-level checks on the order search core.
// ----------------------------------------------------------------------------
module wtos_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [1:0] status,
  input logic [4:0] job_id,
  input logic last
);
  import wtos_pkg::*;

  // never accepts input while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open during output");

  // status results carry no job number and end the run
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_FOUND) |-> (job_id == '0 && last))
    else $error("bad status result");

  // found results carry a job number
  a_found_id: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FOUND) |-> job_id != '0) else $error("zero id");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(job_id) && $stable(status)))
    else $error("result changed under stall");

endmodule

bind weighted_tardiness_order_search_core wtos_checker u_chk (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .status, .job_id, .last
);

// ===== tb/weighted_tardiness_order_search_checker.sv =====
// ----------------------------------------------------------------------------
// weighted_tardiness_order_search_checker
// Watches the job and result channels, predicts the job order (or status) for
// every completed load and compares each result transaction against it.
// ----------------------------------------------------------------------------
module weighted_tardiness_order_search_checker (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [wtos_pkg::LIM_W-1:0] cfg_wdata,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [wtos_pkg::LEN_W-1:0] job_length,
  input  logic [wtos_pkg::DL_W-1:0]  job_deadline,
  input  logic [wtos_pkg::WT_W-1:0]  job_weight,
  input  logic                       last_job,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [wtos_pkg::ST_W-1:0]  status,
  input  logic [wtos_pkg::ID_W-1:0]  job_id,
  input  logic                       last,
  output int                         fail_count,
  output int                         pending_count,
  output int                         result_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import wtos_pkg::*;

  typedef struct packed {
    logic [ST_W-1:0] st;
    logic [ID_W-1:0] id;
    logic            fin;
  } order_entry_t;

  localparam int CAP = 16;

  logic [LIM_W-1:0] limit_q;
  logic [LEN_W-1:0] len_q [CAP];
  logic [DL_W-1:0]  dl_q  [CAP];
  logic [WT_W-1:0]  wt_q  [CAP];
  int               loaded;
  bit               dropped;
  order_entry_t     order_q [$];

  // depth-first order search, candidates in index order
  function automatic bit find_order(input int n, output int pick [CAP]);
    int       lvl;
    int       cand [CAP+1];
    longint   t_sv [CAP+1];
    longint   p_sv [CAP+1];
    bit [CAP-1:0] busy;
    longint   t;
    longint   p;
    int       c;
    lvl = 0; t = 0; p = 0; busy = '0; cand[0] = 0;
    forever begin
      bit back;
      back = 0;
      if (p > longint'(limit_q)) begin
        back = 1;
      end else if (lvl >= n) begin
        return 1;
      end else begin
        c = cand[lvl];
        while (c < n && busy[c]) c++;
        if (c < n) begin
          cand[lvl] = c + 1;
          t_sv[lvl] = t;
          p_sv[lvl] = p;
          pick[lvl] = c;
          busy[c] = 1;
          t += len_q[c];
          if (t > dl_q[c]) p += (t - dl_q[c]) * longint'(wt_q[c]);
          lvl++;
          cand[lvl] = 0;
        end else begin
          back = 1;
        end
      end
      if (back) begin
        if (lvl == 0) return 0;
        lvl--;
        busy[pick[lvl]] = 0;
        t = t_sv[lvl];
        p = p_sv[lvl];
      end
    end
  endfunction

  // prediction on accepted jobs, comparison on accepted results
  always @(posedge clk) begin
    int           pick [CAP];
    order_entry_t e;
    order_entry_t got;
    if (rst) begin
      limit_q <= LIM_W'(1);
      loaded = 0;
      dropped = 0;
      fail_count <= 0;
      result_count <= 0;
      pending_count <= 0;
      order_q.delete();
    end else begin
      if (cfg_we) limit_q <= cfg_wdata;
      if (in_valid && !in_stall) begin
        if (loaded < CAP) begin
          len_q[loaded] = job_length;
          dl_q[loaded] = job_deadline;
          wt_q[loaded] = job_weight;
          loaded++;
        end else begin
          dropped = 1;
        end
        if (last_job) begin
          if (dropped) begin
            order_q.push_back('{ST_OVERFLOW, '0, 1'b1});
          end else if (find_order(loaded, pick)) begin
            for (int k = 0; k < loaded; k++)
              order_q.push_back('{ST_FOUND, ID_W'(pick[k] + 1), k == loaded - 1});
          end else begin
            order_q.push_back('{ST_NONE, '0, 1'b1});
          end
          loaded = 0;
          dropped = 0;
        end
      end
      if (out_valid && !out_stall) begin
        got = '{status, job_id, last};
        result_count <= result_count + 1;
        if (order_q.size() == 0) begin
          $display("%0t: unexpected result st=%0d id=%0d last=%0d",
                   $time, status, job_id, last);
          fail_count <= fail_count + 1;
        end else begin
          e = order_q.pop_front();
          if (got != e) begin
            $display("%0t: mismatch expected st=%0d id=%0d last=%0d, got st=%0d id=%0d last=%0d",
                     $time, e.st, e.id, e.fin, status, job_id, last);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_count <= order_q.size();
    end
  end
endmodule

// ===== tb/weighted_tardiness_order_search_core_test.sv =====
// ----------------------------------------------------------------------------
// weighted_tardiness_order_search_core_test
// Drives job loads of varied size and penalty limits through the search core,
// with bursty input and random result stalls; the checker judges results.
// ----------------------------------------------------------------------------
module weighted_tardiness_order_search_core_test;
  timeunit 1ns;
  timeprecision 1ps;
  import wtos_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;

  logic             clk = 0;
  logic             rst = 1;
  logic             cfg_we = 0;
  logic [LIM_W-1:0] cfg_wdata = '0;
  logic             in_valid = 0;
  logic             in_stall;
  logic [LEN_W-1:0] job_length = '0;
  logic [DL_W-1:0]  job_deadline = '0;
  logic [WT_W-1:0]  job_weight = '0;
  logic             last_job = 0;
  logic             out_valid;
  logic             out_stall = 0;
  logic [ST_W-1:0]  status;
  logic [ID_W-1:0]  job_id;
  logic             last;
  int               fail_count;
  int               pending_count;
  int               result_count;
  int               cycles = 0;
  int               jobs_sent = 0;
  int               loads_sent = 0;
  bit               hold_off = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  weighted_tardiness_order_search_core u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .job_length(job_length),
    .job_deadline(job_deadline), .job_weight(job_weight), .last_job(last_job),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .job_id(job_id), .last(last)
  );

  weighted_tardiness_order_search_checker u_chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .job_length(job_length),
    .job_deadline(job_deadline), .job_weight(job_weight), .last_job(last_job),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .job_id(job_id), .last(last), .fail_count(fail_count),
    .pending_count(pending_count), .result_count(result_count)
  );

  // cycle limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // result stall pattern, with one long hold-off
  always @(posedge clk) begin
    int mode;
    mode = (cycles / 300) % 3;
    if (hold_off) out_stall <= 1;
    else if (mode == 0) out_stall <= 0;
    else if (mode == 1) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 1) == 0);
  end

  // one job transaction, held until accepted
  task automatic send_job(input logic [LEN_W-1:0] l, input logic [DL_W-1:0] d,
                          input logic [WT_W-1:0] w, input logic fin);
    in_valid <= 1;
    job_length <= l;
    job_deadline <= d;
    job_weight <= w;
    last_job <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    jobs_sent++;
    if (fin) loads_sent++;
  endtask

  task automatic pause_sender();
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // random load of n jobs; tight loads keep deadlines loose so searches end
  task automatic send_load(input int n, input int kind);
    logic [LEN_W-1:0] l;
    logic [DL_W-1:0]  d;
    logic [WT_W-1:0]  w;
    for (int k = 0; k < n; k++) begin
      case (kind)
        0: begin
          l = LEN_W'($urandom_range(0, 20)); d = DL_W'($urandom_range(0, 120));
          w = WT_W'($urandom_range(0, 4));
        end
        1: begin
          l = LEN_W'($urandom); d = DL_W'($urandom); w = WT_W'($urandom);
        end
        default: begin
          l = LEN_W'($urandom_range(0, 3));
          d = DL_W'(32'hFFFFF - $urandom_range(0, 3));
          w = WT_W'($urandom);
        end
      endcase
      send_job(l, d, w, k == n - 1);
      pause_sender();
    end
  endtask

  task automatic write_limit(input logic [LIM_W-1:0] v);
    in_valid <= 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  initial begin
    int n;
    int kind;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: reset limit, single jobs at field extremes
    send_job('0, '0, '0, 1);
    send_job('1, '0, '1, 1);
    send_job('1, '1, '1, 1);
    send_job(16'd5, 20'd3, 16'd1, 0);
    send_job(16'd1, 20'd10, 16'd1, 1);
    write_limit('0);
    send_job(16'd2, 20'd1, 16'd1, 1);
    send_job(16'd2, 20'd2, 16'd9, 0);
    send_job(16'd2, 20'd4, 16'd9, 1);
    write_limit('1);
    send_job('1, '0, '1, 0);
    send_job('1, '0, '1, 1);
    // seventeen jobs: overflow, then a full sixteen-job load
    for (int k = 0; k < 17; k++) send_job(16'd1, 20'hFFFFF, 16'd1, k == 16);
    send_load(16, 2);
    write_limit(31'd50);
    send_job(16'd10, 20'd5, 16'd3, 0);
    send_job(16'd1, 20'd1, 16'd2, 1);

    // random loads under several limits, with one long receiver hold-off
    while (jobs_sent < 380) begin
      if (loads_sent % 25 == 0) begin
        case ($urandom_range(0, 3))
          0: write_limit('0);
          1: write_limit('1);
          2: write_limit(LIM_W'($urandom_range(1, 200)));
          default: write_limit(LIM_W'($urandom));
        endcase
      end
      if (loads_sent == 40) begin
        hold_off <= 1;
        fork
          begin
            repeat (400) @(posedge clk);
            hold_off <= 0;
          end
        join_none
      end
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 19) : $urandom_range(1, 6);
      kind = $urandom_range(0, 2);
      send_load(n, kind);
    end
    in_valid <= 0;

    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("ran %0d jobs in %0d loads, %0d results checked", jobs_sent, loads_sent,
             result_count);
    if (fail_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
